// ===== rtl/ppc_pkg.sv =====
// Shared types and constants for the PCB pixel layer classifier.
// No dependencies; imported by the stage files, the top level and the testbench.
package ppc_pkg;

  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 21;

  localparam logic [CfgIdxW-1:0] REG_GOLD   = 4'd0;
  localparam logic [CfgIdxW-1:0] REG_SILK   = 4'd1;
  localparam logic [CfgIdxW-1:0] REG_BOTTOM = 4'd2;
  localparam logic [CfgIdxW-1:0] REG_COPPER = 4'd3;
  localparam logic [CfgIdxW-1:0] REG_SATMIN = 4'd4;
  localparam logic [CfgIdxW-1:0] REG_VALMIN = 4'd5;
  localparam logic [CfgIdxW-1:0] REG_MODE   = 4'd6;
  localparam logic [CfgIdxW-1:0] REG_BARE   = 4'd7;

  // mode bit positions
  localparam int unsigned MODE_TIN   = 0;
  localparam int unsigned MODE_WHITE = 1;
  localparam int unsigned MODE_BARE  = 2;
  localparam int unsigned MODE_BAND  = 3;

  typedef struct packed {
    logic [8:0]  gold;
    logic [7:0]  silk;
    logic [7:0]  bottom;
    logic [7:0]  copper;
    logic [7:0]  sat_min;
    logic [7:0]  val_min;
    logic [3:0]  mode;
    logic [20:0] bare;
  } cfg_t;

  // after color metrics
  typedef struct packed {
    logic [7:0]  mx;
    logic [7:0]  d;
    logic [7:0]  gray;
    logic [23:0] num;
    logic [16:0] dist2;
    logic [15:0] ksq;
  } s1_t;

  // after scaling products
  typedef struct packed {
    logic [7:0]  mx;
    logic [7:0]  gray;
    logic        d_nz;
    logic        lo_any;
    logic [24:0] sat_num;
    logic [24:0] sat_thr;
    logic [22:0] sat_40;
    logic [24:0] h2;
    logic [24:0] hue_lo;
    logic [24:0] hue_hi;
    logic [24:0] h161;
    logic [24:0] h260;
    logic [26:0] pd;
    logic [28:0] pk;
  } s2_t;

  typedef struct packed {
    logic metal;
    logic copper;
    logic mask_open;
    logic silk;
    logic bottom_open;
    logic bare_substrate;
  } lay_t;

endpackage

// ===== rtl/ppc_pix_if.sv =====
// Pixel input channel and layer result channel interfaces.
// Depends on nothing; used by the classifier top level.
interface ppc_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface ppc_lay_if;
  logic valid;
  logic ready;
  logic metal;
  logic copper;
  logic mask_open;
  logic silk;
  logic bottom_open;
  logic bare_substrate;
  modport source (output valid, metal, copper, mask_open, silk, bottom_open,
                  bare_substrate, input ready);
  modport sink   (input valid, metal, copper, mask_open, silk, bottom_open,
                  bare_substrate, output ready);
endinterface

// ===== rtl/ppc_color.sv =====
// Stage 1: max/min, gray, hue numerator and distance to substrate color.
// Depends on ppc_pkg.
module ppc_color (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [7:0]    red_i,
  input  logic [7:0]    green_i,
  input  logic [7:0]    blue_i,
  input  ppc_pkg::cfg_t cfg_i,
  output logic          valid_o,
  output ppc_pkg::s1_t  data_o
);
  import ppc_pkg::*;

  logic [7:0]         mx, mn, d;
  logic signed [25:0] rs, gs, bs, ds, num;
  logic [12:0]        gsum;
  logic signed [9:0]  dr, dg, db;
  logic signed [19:0] dsum;
  logic [6:0]         thr7, thr;
  logic [7:0]         k;
  s1_t                s1_d, s1_q;
  logic               valid_q;

  always_comb begin
    mx = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    mn = red_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    d = mx - mn;
    rs = $signed({18'd0, red_i});
    gs = $signed({18'd0, green_i});
    bs = $signed({18'd0, blue_i});
    ds = $signed({18'd0, d});
    // hue in hundredths of a degree times d; red wins ties, then green
    if (red_i == mx) begin
      num = 26'sd6000 * (gs - bs);
      if (num < 0) num = num + 26'sd36000 * ds;
    end else if (green_i == mx) begin
      num = 26'sd12000 * ds + 26'sd6000 * (bs - rs);
    end else begin
      num = 26'sd24000 * ds + 26'sd6000 * (rs - gs);
    end
    gsum = 13'(11 * red_i) + 13'({green_i, 4'b0}) + 13'(5 * blue_i);
    dr = $signed({2'b0, red_i})   - 10'sd160;
    dg = $signed({2'b0, green_i}) - 10'sd125;
    db = $signed({2'b0, blue_i})  - 10'sd64;
    dsum = dr * dr + dg * dg + db * db;
    thr7 = cfg_i.bare[20:14];
    thr  = (thr7 > 7'd100) ? 7'd100 : thr7;
    k    = 8'd201 - {thr, 1'b0};
    s1_d.mx    = mx;
    s1_d.d     = d;
    s1_d.gray  = gsum[12:5];
    s1_d.num   = num[23:0];
    s1_d.dist2 = dsum[16:0];
    s1_d.ksq   = k * k;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) s1_q <= s1_d;
  end

  assign valid_o = valid_q;
  assign data_o  = s1_q;
endmodule

// ===== rtl/ppc_scale.sv =====
// Stage 2: products that turn the divisions for sat and hue into compares.
// Depends on ppc_pkg.
module ppc_scale (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  ppc_pkg::s1_t  data_i,
  input  ppc_pkg::cfg_t cfg_i,
  output logic          valid_o,
  output ppc_pkg::s2_t  data_o
);
  import ppc_pkg::*;

  logic [8:0]  glo;
  logic [9:0]  ghi;
  logic [16:0] clo;
  logic [17:0] chi;
  logic [15:0] mxs;
  s2_t         s2_d, s2_q;
  logic        valid_q;

  always_comb begin
    glo = cfg_i.gold - 9'd24;
    ghi = {1'b0, cfg_i.gold} + 10'd25;
    clo = 17'(glo * 8'd200);
    chi = 18'(ghi * 8'd200);
    mxs = 16'(data_i.mx * ({1'b0, cfg_i.sat_min} + 9'd1));
    s2_d.mx      = data_i.mx;
    s2_d.gray    = data_i.gray;
    s2_d.d_nz    = (data_i.d != 8'd0);
    s2_d.lo_any  = (cfg_i.gold < 9'd24);
    // sat > S  <=>  131070*d + mx >= 512*mx*(S+1)
    s2_d.sat_num = 25'(17'd131070 * data_i.d) + 25'(data_i.mx);
    s2_d.sat_thr = {mxs, 9'b0};
    s2_d.sat_40  = 23'(15'd20480 * data_i.mx);
    // hue >= K  <=>  2*num + d >= 200*K*d
    s2_d.h2      = {data_i.num, 1'b0} + 25'(data_i.d);
    s2_d.hue_lo  = 25'(clo * data_i.d);
    s2_d.hue_hi  = 25'(chi * data_i.d);
    s2_d.h161    = 25'(15'd32200 * data_i.d);
    s2_d.h260    = 25'(16'd52000 * data_i.d);
    s2_d.pd      = 27'(11'd1600 * data_i.dist2);
    s2_d.pk      = 29'(13'd7803 * data_i.ksq);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) s2_q <= s2_d;
  end

  assign valid_o = valid_q;
  assign data_o  = s2_q;
endmodule

// ===== rtl/ppc_decide.sv =====
// Stage 3: threshold compares and layer decision, output register.
// Depends on ppc_pkg.
module ppc_decide (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  ppc_pkg::s2_t  data_i,
  input  ppc_pkg::cfg_t cfg_i,
  output logic          valid_o,
  output ppc_pkg::lay_t data_o
);
  import ppc_pkg::*;

  logic        sat_gt, sat_lt40, gold_hue, silver, metal, silk_raw, under, bare;
  logic [8:0]  cop_lo, cop_raw, cop_thr;
  logic [6:0]  fa, fc, lo, hi;
  logic [15:0] gp, glo_b, ghi_b;
  lay_t        lay_d, lay_q;
  logic        valid_q;

  always_comb begin
    sat_gt   = data_i.d_nz && (data_i.sat_num >= data_i.sat_thr);
    sat_lt40 = !data_i.d_nz || (data_i.sat_num < {2'b0, data_i.sat_40});
    gold_hue = data_i.d_nz && (data_i.lo_any || data_i.h2 >= data_i.hue_lo)
               && (data_i.h2 < data_i.hue_hi);
    silver   = sat_lt40 || (data_i.d_nz && data_i.h2 >= data_i.h161
               && data_i.h2 < data_i.h260);
    if (cfg_i.mode[MODE_TIN]) begin
      metal = silver && ({1'b0, data_i.mx} > cfg_i.gold);
    end else begin
      metal = gold_hue && sat_gt && (data_i.mx > cfg_i.val_min);
    end

    // copper threshold clamped into bottom+1 .. 254
    cop_lo  = {1'b0, cfg_i.bottom} + 9'd1;
    if (cop_lo > 9'd254) cop_lo = 9'd254;
    cop_raw = {1'b0, cfg_i.copper};
    if (cop_raw > 9'd254) cop_raw = 9'd254;
    cop_thr = (cop_raw < cop_lo) ? cop_lo : cop_raw;

    silk_raw = (data_i.gray > cfg_i.silk) && !metal;
    under    = !metal && !silk_raw && ({1'b0, data_i.gray} > cop_thr);

    // gray percent band, compared as 200*gray+255 against 510*pct
    fa = cfg_i.bare[6:0];
    fc = cfg_i.bare[13:7];
    lo = (fa < fc) ? fa : fc;
    hi = (fa < fc) ? fc : fa;
    if (lo > 7'd100) lo = 7'd100;
    if (hi > 7'd100) hi = 7'd100;
    gp    = 16'(data_i.gray * 8'd200) + 16'd255;
    glo_b = 16'(lo * 9'd510);
    ghi_b = 16'(({1'b0, hi} + 8'd1) * 9'd510);

    bare = 1'b0;
    if (cfg_i.mode[MODE_BARE] && !metal) begin
      if (cfg_i.mode[MODE_BAND]) begin
        bare = (gp >= glo_b) && (gp < ghi_b);
      end else begin
        bare = ({2'b0, data_i.pd} <= data_i.pk);
      end
    end

    lay_d.metal          = metal;
    lay_d.copper         = metal || under;
    lay_d.mask_open      = metal || (silk_raw && !cfg_i.mode[MODE_WHITE]);
    lay_d.silk           = silk_raw && !bare;
    lay_d.bottom_open    = data_i.gray > cfg_i.bottom;
    lay_d.bare_substrate = bare;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) lay_q <= lay_d;
  end

  assign valid_o = valid_q;
  assign data_o  = lay_q;
endmodule

// ===== rtl/pcb_pixel_layer_classifier.sv =====
// Three register stages (color metrics, scaling products, compares) take an
// accepted pixel beat to its result beat. Throughput: one pixel per cycle
// while the result side is ready; each stage holds only while the next one
// is full and stalled, so empty stages keep filling under backpressure.
// Reset: asynchronous active low; clears stage valid bits and loads the
// register defaults. Depends on ppc_pkg, ppc_pix_if/ppc_lay_if and stages.
module pcb_pixel_layer_classifier (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  ppc_pix_if.sink                         pix_in,
  ppc_lay_if.source                       lay_out,
  input  logic                            cfg_we_i,
  input  logic [ppc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [ppc_pkg::CfgDataW-1:0]    cfg_data_i
);
  import ppc_pkg::*;

  cfg_t cfg_q;
  logic v1, v2, v3;
  logic en1, en2, en3;
  s1_t  s1;
  s2_t  s2;
  lay_t lay;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gold    <= 9'd45;
      cfg_q.silk    <= 8'd200;
      cfg_q.bottom  <= 8'd100;
      cfg_q.copper  <= 8'd150;
      cfg_q.sat_min <= 8'd60;
      cfg_q.val_min <= 8'd100;
      cfg_q.mode    <= 4'd0;
      cfg_q.bare    <= 21'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GOLD:   cfg_q.gold    <= cfg_data_i[8:0];
        REG_SILK:   cfg_q.silk    <= cfg_data_i[7:0];
        REG_BOTTOM: cfg_q.bottom  <= cfg_data_i[7:0];
        REG_COPPER: cfg_q.copper  <= cfg_data_i[7:0];
        REG_SATMIN: cfg_q.sat_min <= cfg_data_i[7:0];
        REG_VALMIN: cfg_q.val_min <= cfg_data_i[7:0];
        REG_MODE:   cfg_q.mode    <= cfg_data_i[3:0];
        REG_BARE:   cfg_q.bare    <= cfg_data_i[20:0];
        default: ;
      endcase
    end
  end

  // a stage advances when it is empty or the next one advances
  assign en3 = !v3 || lay_out.ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign pix_in.ready = en1;

  ppc_color u_color (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en1),
    .valid_i (pix_in.valid),
    .red_i   (pix_in.red),
    .green_i (pix_in.green),
    .blue_i  (pix_in.blue),
    .cfg_i   (cfg_q),
    .valid_o (v1),
    .data_o  (s1)
  );

  ppc_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en2),
    .valid_i (v1),
    .data_i  (s1),
    .cfg_i   (cfg_q),
    .valid_o (v2),
    .data_o  (s2)
  );

  ppc_decide u_decide (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en3),
    .valid_i (v2),
    .data_i  (s2),
    .cfg_i   (cfg_q),
    .valid_o (v3),
    .data_o  (lay)
  );

  assign lay_out.valid          = v3;
  assign lay_out.metal          = lay.metal;
  assign lay_out.copper         = lay.copper;
  assign lay_out.mask_open      = lay.mask_open;
  assign lay_out.silk           = lay.silk;
  assign lay_out.bottom_open    = lay.bottom_open;
  assign lay_out.bare_substrate = lay.bare_substrate;

`ifndef SYNTH
  a_metal_layers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3 && lay.metal |-> lay.copper && lay.mask_open)
    else $error("metal pixel without copper or mask opening");

  a_metal_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3 && lay.metal |-> !lay.silk && !lay.bare_substrate)
    else $error("metal pixel also marked silk or bare");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_in.valid && pix_in.ready ##1 lay_out.ready ##1 lay_out.ready |=> v3)
    else $error("result missing three cycles after accepted beat");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2 && !en3 |=> v2 && $stable(s2))
    else $error("stage two lost data under stall");
`endif
endmodule

// ===== tb/pcb_pixel_layer_classifier_tb.sv =====
// Testbench for pcb_pixel_layer_classifier: random and directed pixels against
// an integer predictor of the layer decision. Depends on ppc_pkg and the
// ppc_pix_if / ppc_lay_if interfaces from the RTL.
`timescale 1ns / 1ps

module pcb_pixel_layer_classifier_tb;
  import ppc_pkg::*;

  class layer_board;
    cfg_t cfg;
    lay_t pending[$];
    int   errors;

    function lay_t classify(logic [7:0] r8, logic [7:0] g8, logic [7:0] b8);
      int r, g, b, mx, mn, d, sat, hue, num, h100, dh, gray, gpct;
      int cop_lo, cop_thr, a, c, lo, hi, thr;
      longint dist2, k;
      bit tin, white, bare_en, band, metal, silk_raw, under, bare, silver;
      lay_t o;
      r = r8; g = g8; b = b8;
      tin = cfg.mode[MODE_TIN]; white = cfg.mode[MODE_WHITE];
      bare_en = cfg.mode[MODE_BARE]; band = cfg.mode[MODE_BAND];
      mx = r; if (g > mx) mx = g; if (b > mx) mx = b;
      mn = r; if (g < mn) mn = g; if (b < mn) mn = b;
      d = mx - mn;
      if (d == 0) begin
        sat = 0; hue = -1;
      end else begin
        sat = ((2 * d * 65535 + mx) / (2 * mx)) >> 8;
        if (r == mx) begin
          num = 6000 * (g - b);
          if (num < 0) num += 36000 * d;
        end else if (g == mx) num = 12000 * d + 6000 * (b - r);
        else num = 24000 * d + 6000 * (r - g);
        h100 = (2 * num + d) / (2 * d);
        hue = h100 / 100;
      end
      if (!tin) begin
        dh = hue - int'(cfg.gold);
        if (dh < 0) dh = -dh;
        metal = dh < 25 && sat > int'(cfg.sat_min) && mx > int'(cfg.val_min);
      end else begin
        silver = sat < 40 || (hue > 160 && hue < 260);
        metal = silver && mx > int'(cfg.gold);
      end
      gray = (r * 11 + g * 16 + b * 5) / 32;
      gpct = (200 * gray + 255) / 510;
      cop_lo = int'(cfg.bottom) + 1; if (cop_lo > 254) cop_lo = 254;
      cop_thr = cfg.copper > 254 ? 254 : int'(cfg.copper);
      if (cop_thr < cop_lo) cop_thr = cop_lo;
      silk_raw = gray > int'(cfg.silk) && !metal;
      under = !metal && !silk_raw && gray > cop_thr;
      bare = 0;
      if (bare_en && !metal) begin
        if (band) begin
          a = cfg.bare[6:0]; c = cfg.bare[13:7];
          lo = a < c ? a : c; hi = a < c ? c : a;
          if (lo > 100) lo = 100;
          if (hi > 100) hi = 100;
          bare = gpct >= lo && gpct <= hi;
        end else begin
          thr = cfg.bare[20:14]; if (thr > 100) thr = 100;
          dist2 = (r - 160) * (r - 160) + (g - 125) * (g - 125) + (b - 64) * (b - 64);
          k = 201 - 2 * thr;
          bare = 1600 * dist2 <= 7803 * k * k;
        end
      end
      o.metal = metal; o.copper = metal || under;
      o.mask_open = metal || (silk_raw && !white);
      o.silk = silk_raw && !bare; o.bottom_open = gray > int'(cfg.bottom);
      o.bare_substrate = bare;
      return o;
    endfunction

    function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      pending.push_back(classify(r, g, b));
    endfunction

    function void check_layers(lay_t got);
      lay_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat %b", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (want !== got) begin
        $display("%0t: layer mismatch exp m%b c%b o%b s%b b%b x%b act m%b c%b o%b s%b b%b x%b",
                 $time, want.metal, want.copper, want.mask_open, want.silk,
                 want.bottom_open, want.bare_substrate, got.metal, got.copper,
                 got.mask_open, got.silk, got.bottom_open, got.bare_substrate);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni, cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  ppc_pix_if pix();
  ppc_lay_if lay();
  layer_board board;
  bit src_idle_en, snk_idle_en;
  int hold_cycles;

  pcb_pixel_layer_classifier dut (
    .clk_i, .rst_ni, .pix_in(pix.sink), .lay_out(lay.source),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

  // result side: random stalls plus an optional long hold-off
  initial begin
    int gap;
    lay.ready = 0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        lay.ready <= 0;
        hold_cycles--;
      end else if (snk_idle_en && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 9);
        lay.ready <= 0;
        repeat (gap - 1) @(negedge clk_i);
      end else lay.ready <= 1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && lay.valid && lay.ready)
      board.check_layers('{lay.metal, lay.copper, lay.mask_open, lay.silk,
                           lay.bottom_open, lay.bare_substrate});
  end

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      pix.valid <= 0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    pix.valid <= 1; pix.red <= r; pix.green <= g; pix.blue <= b;
    do @(posedge clk_i); while (!pix.ready);
    board.note_pixel(r, g, b);
    @(negedge clk_i);
  endtask

  task automatic drain();
    int n;
    pix.valid <= 0;
    n = 0;
    while (board.pending.size() != 0 && n < 100000) begin
      @(negedge clk_i);
      n++;
    end
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 0;
    case (idx)
      REG_GOLD:   board.cfg.gold    = val[8:0];
      REG_SILK:   board.cfg.silk    = val[7:0];
      REG_BOTTOM: board.cfg.bottom  = val[7:0];
      REG_COPPER: board.cfg.copper  = val[7:0];
      REG_SATMIN: board.cfg.sat_min = val[7:0];
      REG_VALMIN: board.cfg.val_min = val[7:0];
      REG_MODE:   board.cfg.mode    = val[3:0];
      REG_BARE:   board.cfg.bare    = val[20:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // near the bare-substrate color or the gold hue, gray, otherwise anything
  task automatic send_random();
    int r, g, b;
    case ($urandom_range(0, 3))
      0: begin
        r = 160 + $signed($urandom_range(0, 60)) - 30;
        g = 125 + $signed($urandom_range(0, 60)) - 30;
        b = 64 + $signed($urandom_range(0, 60)) - 30;
      end
      1: begin
        r = $urandom_range(150, 255); g = $urandom_range(80, 220);
        b = $urandom_range(0, 90);
      end
      2: begin
        r = $urandom_range(0, 255); g = r; b = r;
      end
      default: begin
        r = $urandom_range(0, 255); g = $urandom_range(0, 255);
        b = $urandom_range(0, 255);
      end
    endcase
    send_pixel(r[7:0], g[7:0], b[7:0]);
  endtask

  task automatic random_config(bit extreme);
    write_reg(REG_GOLD, extreme ? ($urandom_range(0, 1) ? 511 : 0) : $urandom_range(0, 359));
    write_reg(REG_SILK, extreme ? ($urandom_range(0, 1) ? 255 : 0) : $urandom_range(0, 255));
    write_reg(REG_BOTTOM, extreme ? ($urandom_range(0, 1) ? 255 : 0) : $urandom_range(0, 255));
    write_reg(REG_COPPER, extreme ? ($urandom_range(0, 1) ? 255 : 0) : $urandom_range(0, 255));
    write_reg(REG_SATMIN, $urandom_range(0, 255));
    write_reg(REG_VALMIN, $urandom_range(0, 255));
    write_reg(REG_MODE, $urandom_range(0, 15));
    write_reg(REG_BARE, extreme ? 21'h1FFFFF : $urandom_range(0, 21'h1FFFFF));
  endtask

  initial begin
    board = new();
    board.cfg = '{gold: 45, silk: 200, bottom: 100, copper: 150, sat_min: 60,
                  val_min: 100, mode: 0, bare: 0};
    rst_ni = 0; cfg_we_i = 0; cfg_idx_i = '0; cfg_data_i = '0;
    pix.valid = 0; pix.red = 0; pix.green = 0; pix.blue = 0;
    src_idle_en = 0; snk_idle_en = 0; hold_cycles = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // directed: channel extremes, gray, gold, silver, bare color
    send_pixel(0, 0, 0);       send_pixel(255, 255, 255);
    send_pixel(255, 0, 0);     send_pixel(0, 255, 0);
    send_pixel(0, 0, 255);     send_pixel(220, 180, 40);
    send_pixel(160, 125, 64);  send_pixel(128, 128, 128);
    send_pixel(255, 0, 1);     send_pixel(255, 255, 0);
    drain();
    write_reg(REG_MODE, 4'b0101); write_reg(REG_BARE, {7'd127, 7'd0, 7'd0});
    write_reg(REG_GOLD, 150);
    send_pixel(160, 125, 64);  send_pixel(200, 200, 200);
    send_pixel(100, 120, 200); send_pixel(161, 125, 64);
    drain();
    write_reg(REG_MODE, 4'b1110); write_reg(REG_BARE, {7'd50, 7'd20, 7'd110});
    write_reg(REG_BOTTOM, 254); write_reg(REG_COPPER, 10);
    send_pixel(255, 255, 255); send_pixel(60, 60, 60);
    send_pixel(250, 250, 250); send_pixel(128, 0, 255);
    drain();

    src_idle_en = 1; snk_idle_en = 1;
    for (int phase = 0; phase < 10; phase++) begin
      random_config(phase < 3);
      if (phase == 4) hold_cycles = 60;
      for (int i = 0; i < 90; i++) send_random();
      if (phase == 6) drain();
      drain();
    end
    src_idle_en = 0; snk_idle_en = 0;
    for (int i = 0; i < 150; i++) send_random();
    drain();

    if (board.errors == 0 && board.pending.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule
